FILE: sv/spq_pkg.sv
// shared types, constants and operation codes for the sorted priority queue
// used by spq_cell and sorted_priority_queue; depends on nothing else
package spq_pkg;

    // number of cells in the chain
    localparam int CAPACITY = 16;
    localparam int CNT_W    = $clog2(CAPACITY + 1);
    localparam int DATA_W   = 64;
    localparam int PRIO_W   = 16;
    localparam int KIND_W   = 2;

    // payload reported while the queue holds nothing: pattern of -1.0
    localparam logic [DATA_W-1:0] EMPTY_FRONT = 64'hBFF0_0000_0000_0000;

    // operation codes
    localparam logic [KIND_W-1:0] KIND_INSERT = 2'd0;
    localparam logic [KIND_W-1:0] KIND_POP    = 2'd1;
    localparam logic [KIND_W-1:0] KIND_CLEAR  = 2'd2;

    typedef logic [DATA_W-1:0]        t_data;
    typedef logic signed [PRIO_W-1:0] t_prio;
    typedef logic [CNT_W-1:0]         t_count;

    // broadcast from the top level to every cell
    typedef struct packed {
        logic  load;   // update the chain this cycle
        logic  ins;    // insert (else pop)
        t_data data;   // new payload
        t_prio prio;   // new priority
    } t_cell_ctl;

endpackage

FILE: sv/spq_cell.sv
// one cell of the sorted chain: holds a single entry and shifts with its neighbors
// depends on spq_pkg
module spq_cell (
    input  logic               i_clk,
    input  spq_pkg::t_cell_ctl i_ctl,
    input  logic               i_occupied,
    input  logic               i_left_stay,
    input  spq_pkg::t_data     i_left_data,
    input  spq_pkg::t_prio     i_left_prio,
    input  spq_pkg::t_data     i_right_data,
    input  spq_pkg::t_prio     i_right_prio,
    output logic               o_stay,
    output spq_pkg::t_data     o_data,
    output spq_pkg::t_prio     o_prio
);

    spq_pkg::t_data r_data;
    spq_pkg::t_prio r_prio;
    spq_pkg::t_data n_data;
    spq_pkg::t_prio n_prio;

    // entry keeps its place when it is stored and strictly ahead of the new one
    assign o_stay = i_occupied && (r_prio < i_ctl.prio);

    // next entry: keep, take new, shift from the left on insert, from the right on pop
    always_comb begin
        n_data = r_data;
        n_prio = r_prio;
        if (i_ctl.ins) begin
            if (!o_stay) begin
                if (i_left_stay) begin
                    n_data = i_ctl.data;
                    n_prio = i_ctl.prio;
                end else begin
                    n_data = i_left_data;
                    n_prio = i_left_prio;
                end
            end
        end else begin
            n_data = i_right_data;
            n_prio = i_right_prio;
        end
    end

    // entry storage
    always_ff @(posedge i_clk) begin
        if (i_ctl.load) begin
            r_data <= n_data;
            r_prio <= n_prio;
        end
    end

    assign o_data = r_data;
    assign o_prio = r_prio;

endmodule

FILE: sv/sorted_priority_queue.sv
// sorted priority queue: each accepted input beat gives one registered result beat
// throughput one item per cycle while results are taken; ready drops only on output stall
// each insert or pop is one parallel compare-and-shift step over the chain of CAPACITY cells
// reset (i_rst_n low, synchronous) empties the queue and clears the result valid
// top level; depends on spq_pkg and spq_cell
module sorted_priority_queue (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_valid,
    output logic                      o_ready,
    input  logic [spq_pkg::KIND_W-1:0] i_kind,
    input  spq_pkg::t_data            i_entry_data,
    input  spq_pkg::t_prio            i_entry_priority,
    output logic                      o_valid,
    input  logic                      i_ready,
    output spq_pkg::t_data            o_front_data,
    output logic                      o_is_empty,
    output spq_pkg::t_count           o_entry_count,
    output logic                      o_dropped
);

    localparam spq_pkg::t_count CAP_CNT = spq_pkg::CNT_W'(spq_pkg::CAPACITY);

    spq_pkg::t_count    r_count;
    spq_pkg::t_count    n_count;
    logic               r_out_valid;
    spq_pkg::t_data     r_out_front;
    logic               r_out_empty;
    spq_pkg::t_count    r_out_count;
    logic               r_out_dropped;
    spq_pkg::t_data     n_front;
    logic               n_dropped;
    logic               in_beat;
    logic               full;
    logic               is_ins;
    logic               is_pop;
    spq_pkg::t_cell_ctl ctl;

    spq_pkg::t_data     cell_data [spq_pkg::CAPACITY];
    spq_pkg::t_prio     cell_prio [spq_pkg::CAPACITY];
    logic               cell_stay [spq_pkg::CAPACITY];

    assign o_ready = !r_out_valid || i_ready;
    assign in_beat = i_valid && o_ready;
    assign full    = (r_count == CAP_CNT);
    assign is_ins  = (i_kind == spq_pkg::KIND_INSERT);
    assign is_pop  = (i_kind == spq_pkg::KIND_POP);

    // broadcast to the cells
    assign ctl.load = in_beat && ((is_ins && !full) || (is_pop && (r_count != '0)));
    assign ctl.ins  = is_ins;
    assign ctl.data = i_entry_data;
    assign ctl.prio = i_entry_priority;

    // chain of cells, head at index 0
    for (genvar g = 0; g < spq_pkg::CAPACITY; g++) begin : g_cell
        logic           left_stay;
        spq_pkg::t_data left_data;
        spq_pkg::t_prio left_prio;
        spq_pkg::t_data right_data;
        spq_pkg::t_prio right_prio;

        if (g == 0) begin : g_head
            assign left_stay = 1'b1;
            assign left_data = cell_data[g];
            assign left_prio = cell_prio[g];
        end else begin : g_mid
            assign left_stay = cell_stay[g-1];
            assign left_data = cell_data[g-1];
            assign left_prio = cell_prio[g-1];
        end
        if (g == spq_pkg::CAPACITY - 1) begin : g_tail
            assign right_data = cell_data[g];
            assign right_prio = cell_prio[g];
        end else begin : g_body
            assign right_data = cell_data[g+1];
            assign right_prio = cell_prio[g+1];
        end

        spq_cell u_cell (
            .i_clk        (i_clk),
            .i_ctl        (ctl),
            .i_occupied   (r_count > spq_pkg::CNT_W'(g)),
            .i_left_stay  (left_stay),
            .i_left_data  (left_data),
            .i_left_prio  (left_prio),
            .i_right_data (right_data),
            .i_right_prio (right_prio),
            .o_stay       (cell_stay[g]),
            .o_data       (cell_data[g]),
            .o_prio       (cell_prio[g])
        );
    end

    // next count, next front and drop flag
    always_comb begin
        n_count   = r_count;
        n_front   = cell_data[0];
        n_dropped = 1'b0;
        case (i_kind)
            spq_pkg::KIND_INSERT: begin
                if (full) begin
                    n_dropped = 1'b1;
                end else begin
                    n_count = r_count + 1'b1;
                    if (!cell_stay[0]) begin
                        n_front = i_entry_data;
                    end
                end
            end
            spq_pkg::KIND_POP: begin
                if (r_count != '0) begin
                    n_count = r_count - 1'b1;
                end
                n_front = cell_data[1];
            end
            spq_pkg::KIND_CLEAR: begin
                n_count = '0;
            end
            default: begin
                n_count = r_count;
            end
        endcase
        if (n_count == '0) begin
            n_front = spq_pkg::EMPTY_FRONT;
        end
    end

    // count and output valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (in_beat) begin
                r_count     <= n_count;
                r_out_valid <= 1'b1;
            end else if (i_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // result payload
    always_ff @(posedge i_clk) begin
        if (in_beat) begin
            r_out_front   <= n_front;
            r_out_empty   <= (n_count == '0);
            r_out_count   <= n_count;
            r_out_dropped <= n_dropped;
        end
    end

    assign o_valid       = r_out_valid;
    assign o_front_data  = r_out_front;
    assign o_is_empty    = r_out_empty;
    assign o_entry_count = r_out_count;
    assign o_dropped     = r_out_dropped;

    // count never passes capacity
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CAP_CNT)
        else $error("entry count above capacity");

    // empty flag agrees with the reported count
    a_empty_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_is_empty == (o_entry_count == '0)))
        else $error("empty flag and count disagree");

    // a dropped insert only happens on a full queue
    a_drop_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_dropped) |-> (o_entry_count == CAP_CNT))
        else $error("drop reported on a queue that is not full");

    // an accepted insert into a queue with room grows it by one
    a_insert_grow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_beat && is_ins && !full) |=> (r_count == $past(r_count) + 1'b1))
        else $error("insert did not grow the queue");

endmodule

FILE: tb/sorted_priority_queue_tb.sv
// self-checking testbench for sorted_priority_queue: directed and random queue traffic
// with a running sorted-queue predictor; depends on spq_pkg and the sorted_priority_queue rtl
`timescale 1ns / 1ps

module sorted_priority_queue_tb;

    // kind code that the block must ignore
    localparam logic [spq_pkg::KIND_W-1:0] KIND_UNUSED = 2'd3;
    localparam int MAX_SHOWN = 10;

    typedef struct packed {
        spq_pkg::t_data  front;
        logic            empty;
        spq_pkg::t_count count;
        logic            dropped;
    } t_queue_report;

    typedef enum int {RX_ALWAYS, RX_PATTERN} t_rx_mode;
    typedef enum int {PRIO_NARROW, PRIO_FULL, PRIO_EDGE} t_prio_mode;

    logic                       i_clk = 1'b0;
    logic                       i_rst_n = 1'b0;
    logic                       i_valid = 1'b0;
    logic                       o_ready;
    logic [spq_pkg::KIND_W-1:0] i_kind = spq_pkg::KIND_INSERT;
    spq_pkg::t_data             i_entry_data = '0;
    spq_pkg::t_prio             i_entry_priority = '0;
    logic                       o_valid;
    logic                       i_ready = 1'b0;
    spq_pkg::t_data             o_front_data;
    logic                       o_is_empty;
    spq_pkg::t_count            o_entry_count;
    logic                       o_dropped;

    // predictor state: entries kept in ascending priority order
    spq_pkg::t_prio queued_prio [spq_pkg::CAPACITY];
    spq_pkg::t_data queued_data [spq_pkg::CAPACITY];
    int             queued_count = 0;

    t_queue_report reports_pending [$];

    // traffic shaping
    t_rx_mode rx_mode = RX_ALWAYS;
    int       hold_request = 0;
    int       hold_left = 0;
    int       rx_run_left = 0;
    logic     rx_run_ready = 1'b1;
    bit       tx_gaps_on = 1'b1;
    int       tx_burst_left = 0;

    // run statistics
    int items_sent = 0;
    int inserts_sent = 0;
    int inserts_refused = 0;
    int pops_on_empty = 0;
    int clears_sent = 0;
    int unused_sent = 0;
    int results_checked = 0;
    int mismatches = 0;

    sorted_priority_queue dut (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_valid          (i_valid),
        .o_ready          (o_ready),
        .i_kind           (i_kind),
        .i_entry_data     (i_entry_data),
        .i_entry_priority (i_entry_priority),
        .o_valid          (o_valid),
        .i_ready          (i_ready),
        .o_front_data     (o_front_data),
        .o_is_empty       (o_is_empty),
        .o_entry_count    (o_entry_count),
        .o_dropped        (o_dropped)
    );

    always #5 i_clk = ~i_clk;

    // apply one operation to the predicted queue and return the report it should give
    function automatic t_queue_report apply_queue_op(
            input logic [spq_pkg::KIND_W-1:0] kind,
            input spq_pkg::t_data data, input spq_pkg::t_prio prio);
        t_queue_report rep;
        int pos;
        int k;
        rep.dropped = 1'b0;
        case (kind)
            spq_pkg::KIND_INSERT: begin
                if (queued_count >= spq_pkg::CAPACITY) begin
                    rep.dropped = 1'b1;
                end else begin
                    pos = 0;
                    while (pos < queued_count && queued_prio[pos] < prio) pos++;
                    for (k = queued_count; k > pos; k--) begin
                        queued_prio[k] = queued_prio[k-1];
                        queued_data[k] = queued_data[k-1];
                    end
                    queued_prio[pos] = prio;
                    queued_data[pos] = data;
                    queued_count++;
                end
            end
            spq_pkg::KIND_POP: begin
                if (queued_count > 0) begin
                    for (k = 0; k + 1 < queued_count; k++) begin
                        queued_prio[k] = queued_prio[k+1];
                        queued_data[k] = queued_data[k+1];
                    end
                    queued_count--;
                end
            end
            spq_pkg::KIND_CLEAR: begin
                queued_count = 0;
            end
            default: begin
            end
        endcase
        rep.empty = (queued_count == 0);
        rep.front = rep.empty ? spq_pkg::EMPTY_FRONT : queued_data[0];
        rep.count = spq_pkg::t_count'(queued_count);
        return rep;
    endfunction

    function automatic spq_pkg::t_data pick_payload();
        case ($urandom_range(0, 9))
            0: return '0;
            1: return '1;
            2: return spq_pkg::EMPTY_FRONT;
            default: return {$urandom, $urandom};
        endcase
    endfunction

    function automatic spq_pkg::t_prio pick_priority(input t_prio_mode mode);
        int v;
        case (mode)
            PRIO_NARROW: begin
                v = $urandom_range(0, 8);
                return spq_pkg::t_prio'(v - 4);
            end
            PRIO_EDGE: begin
                case ($urandom_range(0, 5))
                    0: return spq_pkg::t_prio'(-32768);
                    1: return spq_pkg::t_prio'(-32767);
                    2: return spq_pkg::t_prio'(-1);
                    3: return spq_pkg::t_prio'(0);
                    4: return spq_pkg::t_prio'(32766);
                    default: return spq_pkg::t_prio'(32767);
                endcase
            end
            default: return spq_pkg::t_prio'($urandom_range(0, 65535));
        endcase
    endfunction

    // send one beat, with a random gap ahead of it when a burst runs out
    task automatic send_item(input logic [spq_pkg::KIND_W-1:0] kind,
                             input spq_pkg::t_data data, input spq_pkg::t_prio prio);
        int gap;
        if (tx_gaps_on && tx_burst_left == 0) begin
            tx_burst_left = $urandom_range(1, 16);
            gap = $urandom_range(0, 6);
            if (gap > 0) begin
                @(negedge i_clk);
                i_valid = 1'b0;
                repeat (gap - 1) @(negedge i_clk);
            end
        end
        if (tx_burst_left > 0) tx_burst_left--;
        @(negedge i_clk);
        i_valid          = 1'b1;
        i_kind           = kind;
        i_entry_data     = data;
        i_entry_priority = prio;
        @(posedge i_clk);
        while (!o_ready) @(posedge i_clk);
        // beat accepted at this edge
        if (kind == spq_pkg::KIND_POP && queued_count == 0) pops_on_empty++;
        reports_pending.push_back(apply_queue_op(kind, data, prio));
        if (kind == KIND_UNUSED) begin
            unused_sent++;
        end else begin
            items_sent++;
            if (kind == spq_pkg::KIND_INSERT) inserts_sent++;
            if (kind == spq_pkg::KIND_CLEAR) clears_sent++;
            if (reports_pending[$].dropped) inserts_refused++;
        end
    endtask

    task automatic report_mismatch(input string what, input spq_pkg::t_data want,
                                   input spq_pkg::t_data got);
        mismatches++;
        if (mismatches <= MAX_SHOWN)
            $display("mismatch at %0t: %s expected %h got %h", $realtime, what, want, got);
    endtask

    // random receiver stalls, plus a long hold-off when one is requested
    always @(negedge i_clk) begin
        if (hold_request > 0) begin
            hold_left = hold_request;
            hold_request = 0;
        end
        if (hold_left > 0) begin
            hold_left--;
            i_ready = 1'b0;
        end else if (rx_mode == RX_ALWAYS) begin
            i_ready = 1'b1;
        end else begin
            if (rx_run_left == 0) begin
                rx_run_ready = ~rx_run_ready;
                rx_run_left = rx_run_ready ? $urandom_range(1, 12) : $urandom_range(1, 4);
            end
            rx_run_left--;
            i_ready = rx_run_ready;
        end
    end

    // compare every result beat with the oldest pending report
    always @(posedge i_clk) begin
        t_queue_report want;
        if (i_rst_n && o_valid && i_ready) begin
            if (reports_pending.size() == 0) begin
                report_mismatch("unexpected result, front", '0, o_front_data);
            end else begin
                want = reports_pending.pop_front();
                results_checked++;
                if (o_front_data !== want.front)
                    report_mismatch("front_data", want.front, o_front_data);
                if (o_is_empty !== want.empty)
                    report_mismatch("is_empty", spq_pkg::t_data'(want.empty),
                                    spq_pkg::t_data'(o_is_empty));
                if (o_entry_count !== want.count)
                    report_mismatch("entry_count", spq_pkg::t_data'(want.count),
                                    spq_pkg::t_data'(o_entry_count));
                if (o_dropped !== want.dropped)
                    report_mismatch("dropped", spq_pkg::t_data'(want.dropped),
                                    spq_pkg::t_data'(o_dropped));
            end
        end
    end

    // pop, clear and an unused code on an empty queue change nothing
    task automatic test_empty_queue_ops();
        send_item(spq_pkg::KIND_POP, '1, spq_pkg::t_prio'(-1));
        send_item(spq_pkg::KIND_CLEAR, {$urandom, $urandom}, spq_pkg::t_prio'(32767));
        send_item(KIND_UNUSED, '1, spq_pkg::t_prio'(-32768));
    endtask

    // priority extremes and ties: among equal priorities the newest is served first
    task automatic test_priority_extremes();
        send_item(spq_pkg::KIND_INSERT, '1, spq_pkg::t_prio'(32767));
        send_item(spq_pkg::KIND_INSERT, '0, spq_pkg::t_prio'(-32768));
        send_item(spq_pkg::KIND_INSERT, 64'h0123_4567_89AB_CDEF, spq_pkg::t_prio'(0));
        send_item(spq_pkg::KIND_INSERT, 64'hFEDC_BA98_7654_3210, spq_pkg::t_prio'(0));
        send_item(spq_pkg::KIND_POP, '0, '0);
        send_item(KIND_UNUSED, {$urandom, $urandom},
                  spq_pkg::t_prio'($urandom_range(0, 65535)));
        send_item(spq_pkg::KIND_POP, '1, '1);
    endtask

    // fill to capacity, refuse two more inserts, then clear
    task automatic test_fill_and_drop();
        while (queued_count < spq_pkg::CAPACITY)
            send_item(spq_pkg::KIND_INSERT, pick_payload(), pick_priority(PRIO_FULL));
        send_item(spq_pkg::KIND_INSERT, {$urandom, $urandom}, spq_pkg::t_prio'(-32768));
        send_item(spq_pkg::KIND_INSERT, '1, spq_pkg::t_prio'(32767));
        send_item(spq_pkg::KIND_CLEAR, '0, '0);
    endtask

    // one random sequence: fill to full, drain to empty, or a mix
    task automatic send_random_sequence();
        t_prio_mode pmode;
        int n;
        int r;
        pmode = t_prio_mode'($urandom_range(0, 2));
        case ($urandom_range(0, 3))
            0: begin
                n = spq_pkg::CAPACITY - queued_count + $urandom_range(0, 3);
                repeat (n)
                    send_item(spq_pkg::KIND_INSERT, pick_payload(), pick_priority(pmode));
            end
            1: begin
                n = queued_count + $urandom_range(0, 2);
                repeat (n)
                    send_item(spq_pkg::KIND_POP, {$urandom, $urandom},
                              pick_priority(PRIO_FULL));
            end
            default: begin
                n = $urandom_range(4, 20);
                repeat (n) begin
                    r = $urandom_range(0, 99);
                    if (r < 55)
                        send_item(spq_pkg::KIND_INSERT, pick_payload(), pick_priority(pmode));
                    else if (r < 90)
                        send_item(spq_pkg::KIND_POP, {$urandom, $urandom},
                                  pick_priority(PRIO_FULL));
                    else if (r < 93)
                        send_item(spq_pkg::KIND_CLEAR, {$urandom, $urandom},
                                  pick_priority(PRIO_FULL));
                    else
                        send_item(KIND_UNUSED, {$urandom, $urandom}, pick_priority(PRIO_FULL));
                end
            end
        endcase
    endtask

    task automatic test_random_traffic(input int item_budget);
        int stop_at;
        stop_at = items_sent + item_budget;
        tx_gaps_on = 1'b1;
        rx_mode = RX_PATTERN;
        while (items_sent < stop_at) send_random_sequence();
    endtask

    // receiver holds off while the sender keeps offering, so the input stalls
    task automatic test_output_hold();
        tx_gaps_on = 1'b0;
        rx_mode = RX_PATTERN;
        hold_request = 150;
        repeat (3) send_random_sequence();
        repeat (20)
            send_item(spq_pkg::KIND_INSERT, pick_payload(), pick_priority(PRIO_NARROW));
    endtask

    // full rate with no idling on either side
    task automatic test_back_to_back(input int item_budget);
        int stop_at;
        stop_at = items_sent + item_budget;
        tx_gaps_on = 1'b0;
        rx_mode = RX_ALWAYS;
        while (items_sent < stop_at) send_random_sequence();
    endtask

    initial begin
        int guard;
        repeat (6) @(negedge i_clk);
        i_rst_n = 1'b1;

        test_empty_queue_ops();
        test_priority_extremes();
        test_fill_and_drop();
        test_random_traffic(600);
        test_output_hold();
        test_back_to_back(250);
        test_random_traffic(250);

        @(negedge i_clk);
        i_valid = 1'b0;
        rx_mode = RX_PATTERN;

        // drain the remaining results, then keep watching for stray results
        guard = 0;
        while (reports_pending.size() != 0 && guard < 5000) begin
            @(posedge i_clk);
            guard++;
        end
        repeat (8) @(posedge i_clk);
        if (reports_pending.size() != 0) begin
            mismatches += reports_pending.size();
            $display("%0d results never arrived", reports_pending.size());
        end

        $display("ran %0d queue operations: %0d inserts (%0d refused on full), %0d clears",
                 items_sent, inserts_sent, inserts_refused, clears_sent);
        $display("%0d pops on empty, %0d unused codes, %0d results checked, %0d mismatches",
                 pops_on_empty, unused_sent, results_checked, mismatches);
        if (mismatches == 0) begin
            $display("sorted_priority_queue verification clean");
        end else begin
            $display("sorted_priority_queue verification failed");
        end
        $finish;
    end

    // overall time limit
    initial begin
        #5_000_000;
        $display("sorted_priority_queue verification failed");
        $finish;
    end

endmodule

FILE: files.f
sv/spq_pkg.sv
sv/spq_cell.sv
sv/sorted_priority_queue.sv
tb/sorted_priority_queue_tb.sv
